[rtl/ffid_pkg.sv]
// Shared types and constants of the first-free identifier allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffid_pkg;

  localparam int unsigned BaseW   = 31;
  localparam int unsigned CountW  = 7;
  localparam int unsigned IdW     = 32;
  localparam int unsigned HandleW = 64;
  localparam int unsigned OffW    = 6;
  localparam int unsigned CfgAddrW = 1;

  localparam logic [CfgAddrW-1:0] CfgIdBase     = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgEntryCount = 1'b1;

  localparam logic OpAcquire = 1'b0;
  localparam logic OpRelease = 1'b1;

  localparam logic [CountW-1:0] EntryCountRst = 7'd64;

  typedef struct packed {
    logic            hit;
    logic [OffW-1:0] offset;
  } scan_res_t;

endpackage

`default_nettype wire

[rtl/ffid_scan.sv]
// Window scanner: finds the lowest free active entry in one map row.
`timescale 1ns / 1ps
`default_nettype none

module ffid_scan #(
  parameter int unsigned SCAN_WIDTH = 8
) (
  input  wire logic [SCAN_WIDTH-1:0]           row_i,
  input  wire logic [ffid_pkg::CountW-1:0]     start_i,
  input  wire logic [ffid_pkg::CountW-1:0]     count_i,
  output ffid_pkg::scan_res_t                  res_o,
  output logic [SCAN_WIDTH-1:0]                onehot_o
);

  logic [SCAN_WIDTH-1:0] free_vec;

  always_comb begin
    for (int j = 0; j < SCAN_WIDTH; j++) begin
      free_vec[j] = !row_i[j] &&
                    (({1'b0, start_i} + (ffid_pkg::CountW+1)'(j)) < {1'b0, count_i});
    end
  end

  always_comb begin
    res_o.hit    = 1'b0;
    res_o.offset = '0;
    for (int j = SCAN_WIDTH - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        res_o.hit    = 1'b1;
        res_o.offset = ffid_pkg::OffW'(j);
      end
    end
  end

  assign onehot_o = free_vec & (~free_vec + SCAN_WIDTH'(1));

endmodule

`default_nettype wire

[rtl/first_free_id_allocator_core.sv]
// Top level: sequencer, allocation map, config registers and output register.
// Acquire: the scanner checks SCAN_WIDTH-entry rows in turn until a free entry is
//   found, ceil(n / SCAN_WIDTH) rows at most and one row when n is 0; a null handle
//   skips the scan. Release: computes the offset from id_base, then clears the map bit.
// One word in work at a time; a single row scanner steps over the map row by row.
// The output register lets the next word enter while a result waits.
// Reset (async, active low) frees every entry, sets id_base to 0 and entry_count to 64.
`timescale 1ns / 1ps
`default_nettype none

module first_free_id_allocator_core #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned SCAN_WIDTH  = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config write port
  input  wire logic                              cfg_we_i,
  input  wire logic [ffid_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  wire logic [ffid_pkg::BaseW-1:0]        cfg_wdata_i,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [95:0]                       s_axis_tdata,  // object_handle, release_id
  input  wire logic                              s_axis_tuser,  // kind
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [ffid_pkg::IdW-1:0]               m_axis_tdata,  // granted_id
  output logic                                   m_axis_tuser   // granted
);

  localparam int unsigned NumEntries = (MAX_ENTRIES < 127) ? MAX_ENTRIES : 127;
  localparam int unsigned NumRows    = (NumEntries + SCAN_WIDTH - 1) / SCAN_WIDTH;
  localparam int unsigned MapW       = NumRows * SCAN_WIDTH;
  localparam int unsigned RowW       = (NumRows > 1) ? $clog2(NumRows) : 1;
  localparam int unsigned CntW       = ffid_pkg::CountW;

  typedef enum logic [2:0] {
    StIdle, StScan, StResp, StRelDiff, StRelApply
  } state_e;

  state_e                       state_q;
  logic [ffid_pkg::BaseW-1:0]   id_base_q;
  logic [CntW-1:0]              entry_count_q;
  logic [MapW-1:0]              map_q, map_d;
  logic [RowW-1:0]              row_q;
  logic [CntW-1:0]              start_q;
  logic [ffid_pkg::IdW-1:0]     rel_id_q;
  logic [ffid_pkg::IdW:0]       diff_q;
  logic                         res_grant_q;
  logic [ffid_pkg::IdW-1:0]     res_id_q;
  logic                         m_valid_q;
  logic                         m_user_q;
  logic [ffid_pkg::IdW-1:0]     m_data_q;

  logic [CntW-1:0]              n_act;
  logic [SCAN_WIDTH-1:0]        row_bits;
  logic [SCAN_WIDTH-1:0]        onehot;
  ffid_pkg::scan_res_t          scan_res;
  logic [CntW:0]                next_start;
  logic                         last_row;
  logic                         out_free;
  logic                         rel_hit;
  logic                         in_fire;

  assign n_act = (entry_count_q > CntW'(NumEntries)) ? CntW'(NumEntries) : entry_count_q;
  assign row_bits   = map_q[row_q * SCAN_WIDTH +: SCAN_WIDTH];
  assign next_start = {1'b0, start_q} + (CntW+1)'(SCAN_WIDTH);
  assign last_row   = next_start >= {1'b0, n_act};
  assign out_free   = !m_valid_q || m_axis_tready;
  assign rel_hit    = !diff_q[ffid_pkg::IdW] &&
                      (diff_q[ffid_pkg::IdW-1:0] < ffid_pkg::IdW'(n_act));
  assign in_fire    = s_axis_tvalid && s_axis_tready;

  ffid_scan #(
    .SCAN_WIDTH (SCAN_WIDTH)
  ) u_scan (
    .row_i    (row_bits),
    .start_i  (start_q),
    .count_i  (n_act),
    .res_o    (scan_res),
    .onehot_o (onehot)
  );

  always_comb begin
    map_d = map_q;
    if (state_q == StScan && scan_res.hit) begin
      map_d[row_q * SCAN_WIDTH +: SCAN_WIDTH] = row_bits | onehot;
    end
    if (state_q == StRelApply && rel_hit) begin
      for (int e = 0; e < MapW; e++) begin
        if (diff_q[CntW-1:0] == CntW'(e)) begin
          map_d[e] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_base_q     <= '0;
      entry_count_q <= ffid_pkg::EntryCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ffid_pkg::CfgIdBase:     id_base_q     <= cfg_wdata_i;
        ffid_pkg::CfgEntryCount: entry_count_q <= cfg_wdata_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      map_q     <= '0;
      row_q     <= '0;
      start_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      map_q <= map_d;
      if (state_q == StResp && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            row_q    <= '0;
            start_q  <= '0;
            rel_id_q <= s_axis_tdata[95:64];
            if (s_axis_tuser == ffid_pkg::OpRelease) begin
              state_q <= StRelDiff;
            end else if (s_axis_tdata[63:0] == '0) begin
              res_grant_q <= 1'b0;
              res_id_q    <= '0;
              state_q     <= StResp;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (scan_res.hit) begin
            res_grant_q <= 1'b1;
            res_id_q    <= {1'b0, id_base_q} + ffid_pkg::IdW'(start_q)
                           + ffid_pkg::IdW'(scan_res.offset);
            state_q     <= StResp;
          end else if (last_row) begin
            res_grant_q <= 1'b0;
            res_id_q    <= '0;
            state_q     <= StResp;
          end else begin
            row_q   <= row_q + RowW'(1);
            start_q <= next_start[CntW-1:0];
          end
        end
        StResp: begin
          if (out_free) begin
            m_user_q  <= res_grant_q;
            m_data_q  <= res_id_q;
            state_q   <= StIdle;
          end
        end
        StRelDiff: begin
          diff_q  <= {1'b0, rel_id_q} - {2'b00, id_base_q};
          state_q <= StRelApply;
        end
        StRelApply: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StResp && !out_free |=> state_q == StResp)
    else $error("result dropped while output register busy");

  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("failed acquire carries nonzero id");

  a_grant_sets_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan && scan_res.hit |=> $countones(map_q) == $past($countones(map_q)) + 1)
    else $error("grant did not set exactly one map bit");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> start_q < n_act || n_act == '0)
    else $error("scan window beyond active entries");

endmodule

`default_nettype wire

[sim/first_free_id_allocator_core_checker.sv]
// Checker for the first-free identifier allocator: mirrors the allocation map and checks grants.
`timescale 1ns / 1ps

module first_free_id_allocator_core_checker #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffid_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ffid_pkg::BaseW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,  // object_handle, release_id
  input  logic                          s_axis_tuser,  // kind
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [ffid_pkg::IdW-1:0]      m_axis_tdata,  // granted_id
  input  logic                          m_axis_tuser,  // granted
  output int unsigned                   mismatch_count_o,
  output int unsigned                   grants_pending_o
);

  typedef struct packed {
    logic                     granted;
    logic [ffid_pkg::IdW-1:0] id;
  } grant_t;

  grant_t                          grant_queue[$];
  logic [ffid_pkg::BaseW-1:0]      base_q;
  logic [ffid_pkg::CountW-1:0]     count_q;
  logic [MAX_ENTRIES-1:0]          taken_map;
  int unsigned                     mismatches = 0;
  int unsigned                     pending_q = 0;

  assign mismatch_count_o = mismatches;
  assign grants_pending_o = pending_q;

  function automatic int unsigned live_entries();
    return (count_q > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_q);
  endfunction

  task automatic free_entry(input logic [ffid_pkg::IdW-1:0] rid);
    logic [ffid_pkg::IdW:0]   lo;
    logic [ffid_pkg::IdW:0]   hi;
    logic [ffid_pkg::IdW-1:0] off;
    lo  = {2'b00, base_q};
    hi  = lo + live_entries();
    off = rid - {1'b0, base_q};
    if ({1'b0, rid} >= lo && {1'b0, rid} < hi) begin
      taken_map[off] = 1'b0;
    end
  endtask

  task automatic take_first_free(input logic [ffid_pkg::HandleW-1:0] handle,
                                 output grant_t g);
    int unsigned n;
    g.granted = 1'b0;
    g.id      = '0;
    n         = live_entries();
    if (handle != '0) begin
      for (int unsigned i = 0; i < n; i++) begin
        if (!taken_map[i]) begin
          taken_map[i] = 1'b1;
          g.granted    = 1'b1;
          g.id         = {1'b0, base_q} + i;
          break;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t seen;
    grant_t want;
    if (!rst_ni) begin
      base_q    = '0;
      count_q   = ffid_pkg::EntryCountRst;
      taken_map = '0;
      grant_queue.delete();
      pending_q <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.granted = m_axis_tuser;
        seen.id      = m_axis_tdata;
        if (grant_queue.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual granted=%0b id=%h",
                   $time, seen.granted, seen.id);
          mismatches++;
        end else begin
          want = grant_queue.pop_front();
          if (seen.granted !== want.granted) begin
            $display("%0t: granted mismatch: expected %0b, actual %0b",
                     $time, want.granted, seen.granted);
            mismatches++;
          end
          if (seen.id !== want.id) begin
            $display("%0t: granted_id mismatch: expected %h, actual %h",
                     $time, want.id, seen.id);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == ffid_pkg::CfgIdBase) begin
          base_q = cfg_wdata_i;
        end else if (cfg_addr_i == ffid_pkg::CfgEntryCount) begin
          count_q = cfg_wdata_i[ffid_pkg::CountW-1:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ffid_pkg::OpRelease) begin
          free_entry(s_axis_tdata[95:64]);
        end else begin
          take_first_free(s_axis_tdata[63:0], want);
          grant_queue.push_back(want);
        end
      end
      pending_q <= grant_queue.size();
    end
  end

endmodule

[sim/first_free_id_allocator_core_test.sv]
// Testbench top for the first-free identifier allocator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module first_free_id_allocator_core_test;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [ffid_pkg::CfgAddrW-1:0]      cfg_addr_i;
  logic [ffid_pkg::BaseW-1:0]         cfg_wdata_i;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [95:0]                        s_axis_tdata;
  logic                               s_axis_tuser;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [ffid_pkg::IdW-1:0]           m_axis_tdata;
  logic                               m_axis_tuser;
  int unsigned                        mismatch_count;
  int unsigned                        grants_pending;
  int unsigned                        cycle_count = 0;
  bit                                 calm = 1'b0;
  bit                                 hold_req = 1'b0;

  first_free_id_allocator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  first_free_id_allocator_core_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .grants_pending_o (grants_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** first_free_id_allocator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic kind, input logic [ffid_pkg::HandleW-1:0] handle,
                           input logic [ffid_pkg::IdW-1:0] rid);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {rid, handle};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic acquire(input logic [ffid_pkg::HandleW-1:0] handle);
    send_word(ffid_pkg::OpAcquire, handle, $urandom());
  endtask

  task automatic release_id(input logic [ffid_pkg::IdW-1:0] rid);
    send_word(ffid_pkg::OpRelease, {$urandom(), $urandom()}, rid);
  endtask

  // drain outstanding grants, then let a trailing release finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (grants_pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic configure(input logic [ffid_pkg::BaseW-1:0] base,
                           input logic [ffid_pkg::CountW-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= ffid_pkg::CfgIdBase;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_addr_i  <= ffid_pkg::CfgEntryCount;
    cfg_wdata_i <= {{(ffid_pkg::BaseW-ffid_pkg::CountW){1'b0}}, count};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [ffid_pkg::CountW-1:0]  counts[12];
    logic [ffid_pkg::BaseW-1:0]   base;
    logic [ffid_pkg::IdW-1:0]     rid;
    logic [ffid_pkg::HandleW-1:0] handle;
    int unsigned                  roll;

    counts = '{7'd64, 7'd1, 7'd127, 7'd9, 7'd0, 7'd63,
               7'd65, 7'd8, 7'd2, 7'd64, 7'd17, 7'd64};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = ffid_pkg::CfgIdBase;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ffid_pkg::OpAcquire;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    acquire('0);
    acquire('1);
    acquire(64'h1);
    release_id('1);
    release_id(32'd64);
    release_id(32'd1);
    release_id(32'd1);
    acquire(64'h8000_0000_0000_0000);
    settle();

    // top of the id space, two entries, both already taken
    configure(31'h7FFF_FFFF, 7'd2);
    acquire(64'h5);
    release_id(32'h7FFF_FFFE);
    release_id(32'h8000_0001);
    release_id(32'h8000_0000);
    acquire(64'h6);
    release_id(32'h7FFF_FFFF);
    acquire(64'h7);
    settle();

    configure(31'd5, 7'd0);
    acquire(64'h9);
    release_id(32'd5);
    settle();

    configure(31'd0, 7'd127);
    acquire(64'hA);
    release_id(32'd63);
    acquire('0);
    settle();

    configure(31'd0, 7'd1);
    release_id(32'd1);
    acquire(64'hB);
    settle();

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: base = '0;
        1: base = 31'h7FFF_FFFF;
        2: base = ffid_pkg::BaseW'($urandom());
        default: base = ffid_pkg::BaseW'($urandom_range(0, 100));
      endcase
      configure(base, counts[p]);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      if (p >= 10) begin
        calm = 1'b1;
      end
      repeat (150) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          handle = (roll < 4) ? '0 : {$urandom(), $urandom()};
          acquire(handle);
        end else if (roll < 90) begin
          rid = {1'b0, base} + $urandom_range(0, 66);
          release_id(rid);
        end else if (roll < 95) begin
          rid = {1'b0, base} - 1;
          release_id(rid);
        end else begin
          release_id($urandom());
        end
      end
      settle();
    end

    if (mismatch_count == 0 && grants_pending == 0) begin
      $display("** first_free_id_allocator_core: PASSED **");
    end else begin
      $display("** first_free_id_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ffid_pkg.sv
rtl/ffid_scan.sv
rtl/first_free_id_allocator_core.sv
sim/first_free_id_allocator_core_checker.sv
sim/first_free_id_allocator_core_test.sv
